[hdl/u8u16_pkg.sv]
// shared types, constants and helper functions for the utf-8 to utf-16 decoder
`timescale 1ns / 1ps
package u8u16_pkg;

   localparam int COUNT_BITS = 16;
   localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

   localparam int UNIT_W  = 16;
   localparam int TOTAL_W = 16;

   localparam int FIFO_DEPTH = 4;
   localparam int FIFO_AW    = $clog2(FIFO_DEPTH);
   localparam int MAX_PUSH   = 3;

   // result kinds
   localparam logic KIND_UNIT    = 1'b0;
   localparam logic KIND_SUMMARY = 1'b1;

   // utf-8 byte classes and surrogate constants
   localparam logic [7:0]  LEAD2_MASK  = 8'hE0;
   localparam logic [7:0]  LEAD2_CODE  = 8'hC0;
   localparam logic [7:0]  LEAD3_MASK  = 8'hF0;
   localparam logic [7:0]  LEAD3_CODE  = 8'hE0;
   localparam logic [7:0]  LEAD4_MASK  = 8'hF8;
   localparam logic [7:0]  LEAD4_CODE  = 8'hF0;
   localparam logic [7:0]  LEAD5_MASK  = 8'hFC;
   localparam logic [7:0]  LEAD5_CODE  = 8'hF8;
   localparam logic [7:0]  LEAD6_MASK  = 8'hFE;
   localparam logic [7:0]  LEAD6_CODE  = 8'hFC;
   localparam logic [7:0]  CONT_MASK   = 8'hC0;
   localparam logic [7:0]  CONT_CODE   = 8'h80;
   localparam logic [31:0] BMP_LIMIT   = 32'h0001_0000;
   localparam logic [31:0] CODE_LIMIT  = 32'h0011_0000;
   localparam logic [15:0] HI_SURR     = 16'hD800;
   localparam logic [15:0] LO_SURR     = 16'hDC00;

   typedef struct packed {
      logic               kind;
      logic [UNIT_W-1:0]  unit;
      logic [TOTAL_W-1:0] total;
      logic               last;
   } result_type;

   // group of results produced by one accepted byte, valid in slots below count
   typedef struct packed {
      logic [1:0]                  count;
      result_type [MAX_PUSH-1:0]   slot;
   } push_type;

   function automatic logic [COUNT_BITS-1:0] cnt_add(input logic [COUNT_BITS-1:0] c,
                                                     input logic [1:0] k);
      logic [COUNT_BITS:0] s;
      s = {1'b0, c} + (COUNT_BITS+1)'(k);
      if (s > {1'b0, COUNT_MAX}) begin
         return COUNT_MAX;
      end
      return s[COUNT_BITS-1:0];
   endfunction

   function automatic logic [TOTAL_W-1:0] sat_total(input logic [COUNT_BITS-1:0] c);
      if (32'(c) > 32'h0000_FFFF) begin
         return '1;
      end
      return TOTAL_W'(c);
   endfunction

endpackage

[hdl/u8u16_core.sv]
// decode state and per-byte result generation
`timescale 1ns / 1ps
module u8u16_core
   import u8u16_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       accept,
   input  logic [7:0] data_byte,
   input  logic       end_of_source,
   output push_type   push
);

   logic [31:0]           partial_ff, partial_in;
   logic [2:0]            remain_ff, remain_in;
   logic [COUNT_BITS-1:0] count_ff, count_in;
   logic                  ended_ff, ended_in;

   logic [31:0]           shifted;
   logic [19:0]           offset;
   logic [1:0]            emit_n;
   logic [UNIT_W-1:0]     unit_a, unit_b;
   logic [COUNT_BITS-1:0] cnt1, cnt2, cnt_after;
   result_type            res_a, res_b, res_sum;

   always_comb begin
      partial_in = partial_ff;
      remain_in  = remain_ff;
      ended_in   = ended_ff;
      emit_n     = 2'd0;
      unit_a     = '0;
      unit_b     = '0;
      shifted    = {partial_ff[25:0], data_byte[5:0]};
      offset     = 20'(shifted - BMP_LIMIT);

      if (!ended_ff) begin
         if (data_byte == 8'h00) begin
            ended_in   = 1'b1;
            partial_in = '0;
            remain_in  = '0;
         end else if (remain_ff == 3'd0) begin
            if (!data_byte[7]) begin
               emit_n = 2'd1;
               unit_a = UNIT_W'(data_byte);
            end else if ((data_byte & LEAD2_MASK) == LEAD2_CODE) begin
               partial_in = 32'(data_byte[4:0]);
               remain_in  = 3'd1;
            end else if ((data_byte & LEAD3_MASK) == LEAD3_CODE) begin
               partial_in = 32'(data_byte[3:0]);
               remain_in  = 3'd2;
            end else if ((data_byte & LEAD4_MASK) == LEAD4_CODE) begin
               partial_in = 32'(data_byte[2:0]);
               remain_in  = 3'd3;
            end else if ((data_byte & LEAD5_MASK) == LEAD5_CODE) begin
               partial_in = 32'(data_byte[1:0]);
               remain_in  = 3'd4;
            end else if ((data_byte & LEAD6_MASK) == LEAD6_CODE) begin
               partial_in = 32'(data_byte[1:0]);
               remain_in  = 3'd5;
            end else begin
               partial_in = '0;
               remain_in  = '0;
            end
         end else if ((data_byte & CONT_MASK) == CONT_CODE) begin
            partial_in = shifted;
            remain_in  = remain_ff - 3'd1;
            if (remain_ff == 3'd1) begin
               partial_in = '0;
               if (shifted < BMP_LIMIT) begin
                  emit_n = 2'd1;
                  unit_a = shifted[UNIT_W-1:0];
               end else if (shifted < CODE_LIMIT) begin
                  // surrogate pair
                  emit_n = 2'd2;
                  unit_a = HI_SURR + 16'(offset[19:10]);
                  unit_b = LO_SURR + 16'(offset[9:0]);
               end
            end
         end else begin
            partial_in = '0;
            remain_in  = '0;
         end
      end

      cnt1 = cnt_add(count_ff, 2'd1);
      cnt2 = cnt_add(count_ff, 2'd2);
      case (emit_n)
         2'd1:    cnt_after = cnt1;
         2'd2:    cnt_after = cnt2;
         default: cnt_after = count_ff;
      endcase
      count_in = cnt_after;

      res_a   = '{kind: KIND_UNIT, unit: unit_a, total: sat_total(cnt1),
                  last: (emit_n == 2'd1) && !end_of_source};
      res_b   = '{kind: KIND_UNIT, unit: unit_b, total: sat_total(cnt2),
                  last: !end_of_source};
      res_sum = '{kind: KIND_SUMMARY, unit: '0, total: sat_total(cnt_after), last: 1'b1};

      push.slot[0] = res_a;
      push.slot[1] = res_b;
      push.slot[2] = res_sum;
      push.count   = emit_n;
      case (emit_n)
         2'd0:    push.slot[0] = res_sum;
         2'd1:    push.slot[1] = res_sum;
         default: push.slot[2] = res_sum;
      endcase
      if (end_of_source) begin
         push.count = emit_n + 2'd1;
         partial_in = '0;
         remain_in  = '0;
         count_in   = '0;
         ended_in   = 1'b0;
      end
      if (!accept) begin
         push.count = 2'd0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         partial_ff <= '0;
         remain_ff  <= '0;
         count_ff   <= '0;
         ended_ff   <= 1'b0;
      end else if (accept) begin
         partial_ff <= partial_in;
         remain_ff  <= remain_in;
         count_ff   <= count_in;
         ended_ff   <= ended_in;
      end
   end

endmodule

[hdl/u8u16_fifo.sv]
// result queue taking up to three results per cycle and giving one per cycle while out_ready is high
`timescale 1ns / 1ps
module u8u16_fifo
   import u8u16_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  push_type   push,
   output logic       space,
   output logic       out_valid,
   input  logic       out_ready,
   output result_type out_item
);

   result_type           mem_ff [FIFO_DEPTH];
   logic [FIFO_AW-1:0]   wr_ff, wr_in;
   logic [FIFO_AW-1:0]   rd_ff, rd_in;
   logic [FIFO_AW:0]     fill_ff, fill_in;
   logic                 pop;

   assign out_valid = (fill_ff != '0);
   assign out_item  = mem_ff[rd_ff];
   assign pop       = out_valid && out_ready;
   // room for a full group of results
   assign space     = (fill_ff <= (FIFO_AW+1)'(FIFO_DEPTH - MAX_PUSH));

   always_comb begin
      wr_in   = wr_ff + FIFO_AW'(push.count);
      rd_in   = rd_ff + FIFO_AW'(pop);
      fill_in = fill_ff + (FIFO_AW+1)'(push.count) - (FIFO_AW+1)'(pop);
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < MAX_PUSH; i++) begin
         if (i < int'(push.count)) begin
            mem_ff[wr_ff + FIFO_AW'(i)] <= push.slot[i];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff   <= '0;
         rd_ff   <= '0;
         fill_ff <= '0;
      end else begin
         wr_ff   <= wr_in;
         rd_ff   <= rd_in;
         fill_ff <= fill_in;
      end
   end

endmodule

[hdl/utf8_to_utf16_decoder_unit.sv]
// utf-8 to utf-16 decoder: stream top level
// throughput: one byte per cycle while each byte yields at most one result and
// rsp_tready is high; a byte yielding up to three results (surrogate pair plus
// summary) is drained one result per cycle while rsp_tready is high, through a
// four-entry result queue, which sets req_tready
// reset: synchronous, clears decode state, unit count and queue
`timescale 1ns / 1ps
module utf8_to_utf16_decoder_unit
   import u8u16_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] data_byte
   input  logic        req_tlast,   // end_of_source
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata,   // [15:0] code_unit, [31:16] unit_total
   output logic        rsp_tuser,   // item_kind
   output logic        rsp_tlast    // last_result
);

   logic       accept;
   push_type   push;
   result_type head;

   assign accept = req_tvalid && req_tready;

   u8u16_core core_i (
      .clock         (clock),
      .reset         (reset),
      .accept        (accept),
      .data_byte     (req_tdata),
      .end_of_source (req_tlast),
      .push          (push)
   );

   u8u16_fifo fifo_i (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .space     (req_tready),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .out_item  (head)
   );

   assign rsp_tdata = {head.total, head.unit};
   assign rsp_tuser = head.kind;
   assign rsp_tlast = head.last;

endmodule
